// ===== rtl/core/dawt_pkg.sv =====
// ----------------------------------------------------------------------------
// dawt_pkg
// Shared widths, register indexes, region codes and window table for the
// device address window translator.
// ----------------------------------------------------------------------------
package dawt_pkg;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned LenW    = 32;
  localparam int unsigned BaseW   = 48;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned LimitW  = BaseW + 1;
  localparam int unsigned OffW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned NumWin  = 9;
  localparam int unsigned WinIdxW = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSram0Base = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSram0Size = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSram1Base = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSram1Size = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTraceBase = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTraceSize = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDramBase  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDramSize  = 3'd7;

  // Region codes as seen on the result.
  localparam logic [1:0] RegionSram0 = 2'd0;
  localparam logic [1:0] RegionSram1 = 2'd1;
  localparam logic [1:0] RegionTrace = 2'd2;
  localparam logic [1:0] RegionDram  = 2'd3;

  // Fixed alias bases.
  localparam logic [BaseW-1:0] Sram0AliasA = 48'h0000_3ff8_0000;
  localparam logic [BaseW-1:0] Sram0AliasB = 48'h0000_3ffc_0000;
  localparam logic [BaseW-1:0] Sram0AliasC = 48'h0000_0002_0000;
  localparam logic [BaseW-1:0] Sram1AliasA = 48'h0000_4000_0000;
  localparam logic [BaseW-1:0] Sram1AliasB = 48'h0000_4004_0000;

  // Window order, highest priority first: SRAM 0 and its three aliases,
  // SRAM 1 and its two aliases, trace, DRAM.
  function automatic logic [1:0] win_region(input logic [WinIdxW-1:0] w);
    logic [1:0] r;
    r = RegionDram;
    if (w < WinIdxW'(4)) begin
      r = RegionSram0;
    end else if (w < WinIdxW'(7)) begin
      r = RegionSram1;
    end else if (w == WinIdxW'(7)) begin
      r = RegionTrace;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/device_address_window_translator.sv =====
// ----------------------------------------------------------------------------
// device_address_window_translator
// Translates a device address and access length into a region hit, region
// number, offset and io-memory flag against nine prioritised windows.
// ----------------------------------------------------------------------------
// Pipeline: three register stages (end sum, window compares, priority select
// and offset) lie between the acceptance of an item and its result.
// Throughput: one item per cycle; each stage holds while its successor is
// full and stalled, so a bubble anywhere is absorbed.
// Reset: all configuration registers clear to zero and every stage empties.
module device_address_window_translator
  import dawt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [AddrW-1:0]    device_address_i,
  input  logic [LenW-1:0]     access_length_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [1:0]          region_o,
  output logic [OffW-1:0]     offset_o,
  output logic                io_memory_o
);

  // Configuration registers.
  logic [BaseW-1:0] sram0_base_q, sram1_base_q, trace_base_q, dram_base_q;
  logic [SizeW-1:0] sram0_size_q, sram1_size_q, trace_bytes_q, dram_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sram0_base_q  <= '0;
      sram0_size_q  <= '0;
      sram1_base_q  <= '0;
      sram1_size_q  <= '0;
      trace_base_q  <= '0;
      trace_bytes_q <= '0;
      dram_base_q   <= '0;
      dram_bytes_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSram0Base: sram0_base_q  <= cfg_data_i[BaseW-1:0];
        RegSram0Size: sram0_size_q  <= cfg_data_i[SizeW-1:0];
        RegSram1Base: sram1_base_q  <= cfg_data_i[BaseW-1:0];
        RegSram1Size: sram1_size_q  <= cfg_data_i[SizeW-1:0];
        RegTraceBase: trace_base_q  <= cfg_data_i[BaseW-1:0];
        RegTraceSize: trace_bytes_q <= cfg_data_i[SizeW-1:0];
        RegDramBase:  dram_base_q   <= cfg_data_i[BaseW-1:0];
        RegDramSize:  dram_bytes_q  <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Per-window base and size, in priority order.
  logic [BaseW-1:0] win_base [NumWin];
  logic [SizeW-1:0] win_size [NumWin];

  always_comb begin
    win_base[0] = sram0_base_q;  win_size[0] = sram0_size_q;
    win_base[1] = Sram0AliasA;   win_size[1] = sram0_size_q;
    win_base[2] = Sram0AliasB;   win_size[2] = sram0_size_q;
    win_base[3] = Sram0AliasC;   win_size[3] = sram0_size_q;
    win_base[4] = sram1_base_q;  win_size[4] = sram1_size_q;
    win_base[5] = Sram1AliasA;   win_size[5] = sram1_size_q;
    win_base[6] = Sram1AliasB;   win_size[6] = sram1_size_q;
    win_base[7] = trace_base_q;  win_size[7] = trace_bytes_q;
    win_base[8] = dram_base_q;   win_size[8] = dram_bytes_q;
  end

  // Window limits are registered off the configuration; the user must change it
  // only while the block is idle, which is not enforced, so they settle before use.
  logic [LimitW-1:0] limit_q [NumWin];
  logic [NumWin-1:0] present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NumWin; w++) begin
        limit_q[w] <= '0;
      end
      present_q <= '0;
    end else begin
      for (int w = 0; w < NumWin; w++) begin
        limit_q[w]   <= {1'b0, win_base[w]} + LimitW'(win_size[w]);
        present_q[w] <= (win_size[w] != '0);
      end
    end
  end

  // Stage handshake: a stage moves on when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: end of access without overflow, and the length and wrap checks.
  logic [AddrW:0]   end_d;
  logic [AddrW:0]   end1_q;
  logic [AddrW-1:0] addr1_q;
  logic             ok1_q;

  assign end_d = {1'b0, device_address_i} + (AddrW + 1)'(access_length_i);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      addr1_q <= device_address_i;
      end1_q  <= end_d;
      ok1_q   <= (access_length_i != '0) && !end_d[AddrW];
    end
  end

  // Stage 2: every window compared in parallel.
  logic [NumWin-1:0] hit_vec_d;
  logic [NumWin-1:0] hit_vec2_q;
  logic [OffW-1:0]   addr2_q;

  always_comb begin
    for (int w = 0; w < NumWin; w++) begin
      hit_vec_d[w] = ok1_q && present_q[w]
                  && (addr1_q >= AddrW'(win_base[w]))
                  && (end1_q <= (AddrW + 1)'(limit_q[w]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      hit_vec2_q <= hit_vec_d;
      addr2_q    <= addr1_q[OffW-1:0];
    end
  end

  // Stage 3: first matching window wins; the offset only needs the low bits.
  logic [WinIdxW-1:0] sel_win;
  logic               any_hit;
  logic [1:0]         sel_region;
  logic [OffW-1:0]    sel_base;

  always_comb begin
    sel_win = '0;
    any_hit = 1'b0;
    for (int w = NumWin - 1; w >= 0; w--) begin
      if (hit_vec2_q[w]) begin
        sel_win = WinIdxW'(w);
        any_hit = 1'b1;
      end
    end
    sel_region = win_region(sel_win);
    sel_base   = win_base[sel_win][OffW-1:0];
  end

  logic             hit3_q;
  logic [1:0]       region3_q;
  logic [OffW-1:0]  offset3_q;
  logic             io3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      hit3_q    <= any_hit;
      region3_q <= any_hit ? sel_region : RegionSram0;
      offset3_q <= any_hit ? (addr2_q - sel_base) : '0;
      io3_q     <= any_hit && (sel_region == RegionSram0 || sel_region == RegionSram1);
    end
  end

  assign out_valid_o = v3_q;
  assign hit_o       = hit3_q;
  assign region_o    = region3_q;
  assign offset_o    = offset3_q;
  assign io_memory_o = io3_q;

endmodule

// ===== rtl/core/dawt_checker.sv =====
// ----------------------------------------------------------------------------
// dawt_checker
// Port-level assertions for the device address window translator, bound to
// the top level.
// ----------------------------------------------------------------------------
module dawt_checker
  import dawt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             hit_o,
  input logic [1:0]       region_o,
  input logic [OffW-1:0]  offset_o,
  input logic             io_memory_o
);

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> region_o == RegionSram0 && offset_o == '0 && !io_memory_o)
    else $error("miss item carries non-zero fields");

  // Only the SRAM regions are io memory.
  a_io_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |->
      io_memory_o == (region_o == RegionSram0 || region_o == RegionSram1))
    else $error("io-memory flag disagrees with region");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(hit_o) && $stable(region_o) && $stable(offset_o)
      && $stable(io_memory_o))
    else $error("stalled result changed");

  // The input only stalls while a result is waiting on a stalled receiver.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no stalled result");

  // Aimed at a result with no input item, but the antecedent already requires
  // out_valid_o low, so the consequent always holds and the check never fires.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(in_valid_i) && !$past(in_valid_i, 2)
      && !$past(in_valid_i, 3) && !$past(out_valid_o) && $past(rst_ni, 3)
      |-> !$past(out_valid_o, 2) || !out_valid_o)
    else $error("result appeared without an input item");

endmodule

bind device_address_window_translator dawt_checker u_dawt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_o       (hit_o),
  .region_o    (region_o),
  .offset_o    (offset_o),
  .io_memory_o (io_memory_o)
);

// ===== tb/sv/tb_device_address_window_translator.sv =====
// ----------------------------------------------------------------------------
// tb_device_address_window_translator
// Self-checking bench for the address window translator. A short table of
// directed lookups covers the reset state, window edges, aliases, zero
// length, address wrap, absent regions and overlap priority. Random lookups
// follow under a series of register settings. Every result is checked field
// by field against a typed value or an in-bench translation of the window map.
// ----------------------------------------------------------------------------
module tb_device_address_window_translator
  import dawt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed alias bases, kept apart from the package so that the bench checks
  // them independently.
  localparam logic [BaseW-1:0] AliasS0A = 48'h0000_3ff8_0000;
  localparam logic [BaseW-1:0] AliasS0B = 48'h0000_3ffc_0000;
  localparam logic [BaseW-1:0] AliasS0C = 48'h0000_0002_0000;
  localparam logic [BaseW-1:0] AliasS1A = 48'h0000_4000_0000;
  localparam logic [BaseW-1:0] AliasS1B = 48'h0000_4004_0000;

  localparam int unsigned PhaseLookups = 120;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned HoldAfter    = 450;
  localparam int unsigned HoldCycles   = 64;

  typedef struct packed {
    logic [BaseW-1:0] sram0_base;
    logic [SizeW-1:0] sram0_size;
    logic [BaseW-1:0] sram1_base;
    logic [SizeW-1:0] sram1_size;
    logic [BaseW-1:0] trace_base;
    logic [SizeW-1:0] trace_bytes;
    logic [BaseW-1:0] dram_base;
    logic [SizeW-1:0] dram_bytes;
  } win_map_t;

  typedef struct packed {
    logic            hit;
    logic [1:0]      region;
    logic [OffW-1:0] offset;
    logic            io;
  } xlate_t;

  typedef enum bit {ByPredictor, AsTyped} row_check_e;

  typedef struct packed {
    logic [1:0]       setting;
    row_check_e       check;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    xlate_t           want;
  } lookup_row_t;

  localparam xlate_t Miss     = '0;
  localparam xlate_t Sram0At0 = '{1'b1, RegionSram0, 32'h0, 1'b1};
  localparam xlate_t Sram1At0 = '{1'b1, RegionSram1, 32'h0, 1'b1};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [AddrW-1:0]    device_address_i;
  logic [LenW-1:0]     access_length_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                hit_o;
  logic [1:0]          region_o;
  logic [OffW-1:0]     offset_o;
  logic                io_memory_o;

  win_map_t    win_map;
  xlate_t      pending_translations[$];
  xlate_t      oldest;
  lookup_row_t dir_rows[$];
  win_map_t    dir_maps [4];

  bit          calm;
  int unsigned failures;
  int unsigned lookups_sent;
  int unsigned results_seen;
  int unsigned misses_seen;
  int unsigned settings_applied;
  int unsigned hits_by_region [4];

  device_address_window_translator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .device_address_i (device_address_i),
    .access_length_i  (access_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .region_o         (region_o),
    .offset_o         (offset_o),
    .io_memory_o      (io_memory_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // A window holds the access when every byte lies inside it; stop is the
  // first byte past the access, kept one bit wider so that it cannot wrap.
  function automatic bit window_holds(logic [AddrW-1:0] addr, logic [AddrW:0] stop,
                                      logic [BaseW-1:0] base, logic [SizeW-1:0] size);
    return size != '0 && addr >= AddrW'(base) && stop <= (65'(base) + 65'(size));
  endfunction

  function automatic xlate_t translate_address(win_map_t m, logic [AddrW-1:0] addr,
                                               logic [LenW-1:0] len);
    logic [AddrW:0]   stop;
    logic [BaseW-1:0] base;
    xlate_t           r;
    r    = '0;
    base = '0;
    stop = {1'b0, addr} + 65'(len);
    if (len == '0 || stop[AddrW]) return Miss;
    r.hit = 1'b1;
    if (window_holds(addr, stop, m.sram0_base, m.sram0_size)) begin
      base = m.sram0_base; r.region = RegionSram0;
    end else if (window_holds(addr, stop, AliasS0A, m.sram0_size)) begin
      base = AliasS0A; r.region = RegionSram0;
    end else if (window_holds(addr, stop, AliasS0B, m.sram0_size)) begin
      base = AliasS0B; r.region = RegionSram0;
    end else if (window_holds(addr, stop, AliasS0C, m.sram0_size)) begin
      base = AliasS0C; r.region = RegionSram0;
    end else if (window_holds(addr, stop, m.sram1_base, m.sram1_size)) begin
      base = m.sram1_base; r.region = RegionSram1;
    end else if (window_holds(addr, stop, AliasS1A, m.sram1_size)) begin
      base = AliasS1A; r.region = RegionSram1;
    end else if (window_holds(addr, stop, AliasS1B, m.sram1_size)) begin
      base = AliasS1B; r.region = RegionSram1;
    end else if (window_holds(addr, stop, m.trace_base, m.trace_bytes)) begin
      base = m.trace_base; r.region = RegionTrace;
    end else if (window_holds(addr, stop, m.dram_base, m.dram_bytes)) begin
      base = m.dram_base; r.region = RegionDram;
    end else begin
      return Miss;
    end
    r.offset = OffW'(addr - AddrW'(base));
    r.io     = (r.region == RegionSram0) || (r.region == RegionSram1);
    return r;
  endfunction

  // Bases cluster around zero, the top of the range and the alias area so
  // that windows overlap often.
  function automatic logic [BaseW-1:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 48'h0000_3ff0_0000 + BaseW'($urandom_range(0, 32'h0014_0000));
      3:       return BaseW'($urandom_range(0, 32'h0004_0000));
      default: return {16'($urandom), $urandom};
    endcase
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return SizeW'($urandom_range(1, 32'h0004_0000));
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
  endtask

  // Size registers get junk in the unused upper data bits; the block must
  // ignore it.
  task automatic program_map(win_map_t m);
    write_reg(RegSram0Base, m.sram0_base);
    write_reg(RegSram0Size, {16'($urandom), m.sram0_size});
    write_reg(RegSram1Base, m.sram1_base);
    write_reg(RegSram1Size, {16'($urandom), m.sram1_size});
    write_reg(RegTraceBase, m.trace_base);
    write_reg(RegTraceSize, {16'($urandom), m.trace_bytes});
    write_reg(RegDramBase,  m.dram_base);
    write_reg(RegDramSize,  {16'($urandom), m.dram_bytes});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    win_map = m;
    settings_applied++;
  endtask

  task automatic push_lookup(logic [AddrW-1:0] addr, logic [LenW-1:0] len, xlate_t want);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    device_address_i <= addr;
    access_length_i  <= len;
    do @(posedge clk_i); while (in_stall_o);
    pending_translations.push_back(want);
    lookups_sent++;
  endtask

  // Stop offering and let every outstanding item drain, plus the pipeline
  // latency, so that the registers can be rewritten safely.
  task automatic drain_lookups();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Stimulus.
  initial begin
    logic [1:0]       cur_setting;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic [BaseW-1:0] base;
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] off;
    logic [AddrW-1:0] room;
    win_map_t         m;
    xlate_t           want;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    device_address_i = '0;
    access_length_i  = '0;
    win_map          = '0;
    calm             = 1'b0;
    cur_setting      = 2'd0;

    dir_maps[0] = '0;
    dir_maps[1] = '{48'h0000_1000_0000, 32'h0001_0000, 48'h0000_2000_0000, 32'h0004_0000,
                    48'h0000_8000_0000, 32'h0010_0000, 48'h0001_0000_0000, 32'h1000_0000};
    // Largest bases and sizes, overlapping windows and a one-byte DRAM region.
    dir_maps[2] = '{48'hffff_ffff_ffff, 32'hffff_ffff, 48'hffff_ffff_0000, 32'hffff_ffff,
                    48'h0000_0000_0000, 32'hffff_ffff, 48'h8000_0000_0000, 32'h0000_0001};
    // SRAM 0 absent: its aliases must fall through to the later windows.
    dir_maps[3] = '{48'h0000_0002_0000, 32'h0000_0000, 48'h0000_3ff8_0000, 32'h0010_0000,
                    48'h0000_0002_0000, 32'h0000_1000, 48'h0000_0000_0000, 32'h0001_0000};

    dir_rows.push_back(lookup_row_t'{2'd0, AsTyped, 64'h0, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd0, AsTyped, 64'h3ff8_0000, 32'h4, Miss});
    dir_rows.push_back(lookup_row_t'{2'd0, AsTyped, '1, '1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, AsTyped, 64'h1000_0000, 32'h0, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, AsTyped, 64'h1000_0000, 32'h4, Sram0At0});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h1000_fffc, 32'h4, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h1000_fffc, 32'h5, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, AsTyped, 64'h3ff8_0000, 32'h8, Sram0At0});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h3ffc_0010, 32'h10, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h0002_0000, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, AsTyped, 64'h2000_0000, 32'h1, Sram1At0});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h4000_0100, 32'h4, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h4004_0000, 32'h4_0000, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h8000_0020, 32'h40, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h1_0fff_ffff, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, ByPredictor, 64'h1_0000_0000, '1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd1, AsTyped, '1, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd2, AsTyped, 64'h0000_ffff_ffff_ffff, '1, Sram0At0});
    dir_rows.push_back(lookup_row_t'{2'd2, ByPredictor, 64'h0001_0000_ffff_fffd, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd2, ByPredictor, 64'h0, '1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd2, ByPredictor, 64'h3ff8_0000, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd2, ByPredictor, 64'h8000_0000_0000, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd2, ByPredictor, 64'h8000_0000_0000, 32'h2, Miss});
    dir_rows.push_back(lookup_row_t'{2'd3, ByPredictor, 64'h3ff8_0000, 32'h1, Miss});
    dir_rows.push_back(lookup_row_t'{2'd3, ByPredictor, 64'h0002_0000, 32'h1, Miss});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur_setting) begin
        drain_lookups();
        program_map(dir_maps[dir_rows[i].setting]);
        cur_setting = dir_rows[i].setting;
      end
      want = (dir_rows[i].check == AsTyped) ? dir_rows[i].want
           : translate_address(win_map, dir_rows[i].addr, dir_rows[i].len);
      push_lookup(dir_rows[i].addr, dir_rows[i].len, want);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      drain_lookups();
      m = '{pick_base(), pick_size(), pick_base(), pick_size(),
            pick_base(), pick_size(), pick_base(), pick_size()};
      program_map(m);
      calm = (p == RandomPhases - 1);
      for (int n = 0; n < PhaseLookups; n++) begin
        if ($urandom_range(0, 9) < 8) begin
          // Aim at one of the nine windows, around its edges or inside it.
          case ($urandom_range(0, 8))
            0:       begin base = win_map.sram0_base; size = win_map.sram0_size;  end
            1:       begin base = AliasS0A;           size = win_map.sram0_size;  end
            2:       begin base = AliasS0B;           size = win_map.sram0_size;  end
            3:       begin base = AliasS0C;           size = win_map.sram0_size;  end
            4:       begin base = win_map.sram1_base; size = win_map.sram1_size;  end
            5:       begin base = AliasS1A;           size = win_map.sram1_size;  end
            6:       begin base = AliasS1B;           size = win_map.sram1_size;  end
            7:       begin base = win_map.trace_base; size = win_map.trace_bytes; end
            default: begin base = win_map.dram_base;  size = win_map.dram_bytes;  end
          endcase
          case ($urandom_range(0, 3))
            0: begin
              addr = AddrW'(base) + AddrW'($urandom_range(0, 4)) - 64'd2;
              len  = $urandom_range(1, 8);
            end
            1: begin
              off  = (size == '0) ? $urandom : SizeW'($urandom % size);
              room = AddrW'(size) - AddrW'(off);
              addr = AddrW'(base) + AddrW'(off);
              len  = LenW'(64'd1 + (AddrW'($urandom) % (room + 64'd1)));
            end
            2: begin
              len  = $urandom_range(1, 16);
              addr = AddrW'(base) + AddrW'(size) - AddrW'(len) + AddrW'($urandom_range(0, 1));
            end
            default: begin
              addr = AddrW'(base);
              len  = size + LenW'($urandom_range(0, 1));
            end
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              addr = {$urandom, $urandom};
              len  = $urandom;
            end
            1: begin
              addr = AddrW'(win_map.sram0_base) + AddrW'($urandom_range(0, 3));
              len  = '0;
            end
            default: begin
              addr = '1 - AddrW'($urandom_range(0, 8));
              len  = $urandom_range(1, 16);
            end
          endcase
        end
        push_lookup(addr, len, translate_address(win_map, addr, len));
      end
    end

    drain_lookups();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d lookups under %0d register settings, reset map included.",
             lookups_sent, settings_applied + 1);
    $display("Hits: sram0 %0d, sram1 %0d, trace %0d, dram %0d; misses %0d.",
             hits_by_region[RegionSram0], hits_by_region[RegionSram1],
             hits_by_region[RegionTrace], hits_by_region[RegionDram], misses_seen);
    if (failures == 0) begin
      $display("** device_address_window_translator: PASSED **");
    end else begin
      $display("** device_address_window_translator: FAILED **");
    end
    $finish;
  end

  // Result side back-pressure. One long hold lets the pipeline fill up and
  // stall its input while lookups keep coming.
  initial begin
    bit held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && lookups_sent >= HoldAfter) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_translations.size() == 0) begin
        $error("result item with nothing outstanding: hit %0b region %0d offset %h",
               hit_o, region_o, offset_o);
        failures++;
      end else begin
        oldest = pending_translations.pop_front();
        results_seen++;
        if (oldest.hit) hits_by_region[oldest.region]++;
        else misses_seen++;
        if (hit_o !== oldest.hit) begin
          $error("hit: expected %0b, got %0b", oldest.hit, hit_o);
          failures++;
        end
        if (region_o !== oldest.region) begin
          $error("region: expected %0d, got %0d", oldest.region, region_o);
          failures++;
        end
        if (offset_o !== oldest.offset) begin
          $error("offset: expected %h, got %h", oldest.offset, offset_o);
          failures++;
        end
        if (io_memory_o !== oldest.io) begin
          $error("io_memory: expected %0b, got %0b", oldest.io, io_memory_o);
          failures++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d items still outstanding.", pending_translations.size());
    $display("** device_address_window_translator: FAILED **");
    $finish;
  end

endmodule
